@@ design/ptq_pkg.sv @@
`timescale 1ns / 1ps

package ptq_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 24;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GAIN_P       = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GAIN_D       = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GAIN_I       = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TORQUE_LIMIT = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FILTER_ALPHA = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TIME_STEP    = 3'd5;

   localparam logic [22:0] TORQUE_LIMIT_RESET = 23'd8388607;
   localparam logic [16:0] FILTER_ALPHA_RESET = 17'd6554;
   localparam logic [23:0] TIME_STEP_RESET    = 24'd16777;

   // 1.0 in Q1.16 and in Q1.20
   localparam logic [16:0]        ALPHA_ONE     = 17'd65536;
   localparam logic signed [27:0] INTEG_ONE     = 28'sd1048576;
   localparam logic signed [27:0] INTEG_NEG_ONE = -28'sd1048576;

   typedef struct packed {
      logic signed [19:0] measured_pos;
      logic signed [19:0] measured_vel;
      logic signed [19:0] desired_pos;
      logic signed [19:0] desired_vel;
   } req_type;

   typedef struct packed {
      logic signed [23:0] torque;
      logic               torque_clamped;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FV_OLD,
      ST_FV_NEW,
      ST_INTEG,
      ST_PROP,
      ST_DERIV,
      ST_GAIN_I,
      ST_SUM_I,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_FV_OLD,
      MUL_FV_NEW,
      MUL_INTEG,
      MUL_PROP,
      MUL_DERIV,
      MUL_GAIN_I
   } mul_op_type;

   typedef enum logic [2:0] {
      ACC_NONE,
      ACC_LOAD,
      ACC_FILTER,
      ACC_INTEG,
      ACC_TAU_P,
      ACC_TAU_D,
      ACC_TAU_I
   } acc_op_type;

   typedef struct packed {
      logic       load;
      mul_op_type mul_op;
      acc_op_type acc_op;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } sts_type;

endpackage

@@ design/ptq_ctrl.sv @@
`timescale 1ns / 1ps

module ptq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ptq_pkg::sts_type  sts,
   output ptq_pkg::cmd_type  cmd
);

   ptq_pkg::state_type state_ff;
   ptq_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ptq_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = ptq_pkg::ST_FV_OLD;
            end
         end
         ptq_pkg::ST_FV_OLD: state_in = ptq_pkg::ST_FV_NEW;
         ptq_pkg::ST_FV_NEW: state_in = ptq_pkg::ST_INTEG;
         ptq_pkg::ST_INTEG:  state_in = ptq_pkg::ST_PROP;
         ptq_pkg::ST_PROP:   state_in = ptq_pkg::ST_DERIV;
         ptq_pkg::ST_DERIV:  state_in = ptq_pkg::ST_GAIN_I;
         ptq_pkg::ST_GAIN_I: state_in = ptq_pkg::ST_SUM_I;
         ptq_pkg::ST_SUM_I:  state_in = ptq_pkg::ST_OUT;
         ptq_pkg::ST_OUT: begin
            if (sts.out_free) begin
               state_in = ptq_pkg::ST_IDLE;
            end
         end
         default: state_in = ptq_pkg::ST_IDLE;
      endcase
   end

   // multiply issued in one state is consumed in the next
   always_comb begin
      req_ready    = 1'b0;
      cmd.load     = 1'b0;
      cmd.mul_op   = ptq_pkg::MUL_NONE;
      cmd.acc_op   = ptq_pkg::ACC_NONE;
      cmd.out_load = 1'b0;
      case (state_ff)
         ptq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ptq_pkg::ST_FV_OLD: begin
            cmd.mul_op = ptq_pkg::MUL_FV_OLD;
         end
         ptq_pkg::ST_FV_NEW: begin
            cmd.mul_op = ptq_pkg::MUL_FV_NEW;
            cmd.acc_op = ptq_pkg::ACC_LOAD;
         end
         ptq_pkg::ST_INTEG: begin
            cmd.mul_op = ptq_pkg::MUL_INTEG;
            cmd.acc_op = ptq_pkg::ACC_FILTER;
         end
         ptq_pkg::ST_PROP: begin
            cmd.mul_op = ptq_pkg::MUL_PROP;
            cmd.acc_op = ptq_pkg::ACC_INTEG;
         end
         ptq_pkg::ST_DERIV: begin
            cmd.mul_op = ptq_pkg::MUL_DERIV;
            cmd.acc_op = ptq_pkg::ACC_TAU_P;
         end
         ptq_pkg::ST_GAIN_I: begin
            cmd.mul_op = ptq_pkg::MUL_GAIN_I;
            cmd.acc_op = ptq_pkg::ACC_TAU_D;
         end
         ptq_pkg::ST_SUM_I: begin
            cmd.acc_op = ptq_pkg::ACC_TAU_I;
         end
         ptq_pkg::ST_OUT: begin
            cmd.out_load = sts.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

@@ design/ptq_datapath.sv @@
`timescale 1ns / 1ps

module ptq_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [ptq_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [ptq_pkg::CSR_DATA_WIDTH-1:0]     csr_data,
   input  ptq_pkg::req_type                       req_data,
   input  ptq_pkg::cmd_type                       cmd,
   output ptq_pkg::sts_type                       sts,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output ptq_pkg::rsp_type                       rsp_data
);

   logic [23:0] gain_p_ff;
   logic [23:0] gain_d_ff;
   logic [23:0] gain_i_ff;
   logic [22:0] torque_limit_ff;
   logic [16:0] filter_alpha_ff;
   logic [23:0] time_step_ff;

   logic signed [19:0] fv_ff, fv_in;
   logic signed [21:0] integ_ff, integ_in;

   logic signed [19:0] mvel_ff;
   logic signed [19:0] dvel_ff;
   logic signed [20:0] perr_ff;

   logic signed [46:0] prod_ff, prod_in;
   logic signed [46:0] acc_ff;
   logic signed [31:0] tau_ff, tau_in;

   logic               rsp_valid_ff;
   ptq_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic [16:0]        alpha_eff;
   logic [16:0]        alpha_rest;
   logic signed [20:0] verr;
   logic signed [24:0] mul_a;
   logic signed [21:0] mul_b;
   logic signed [47:0] filt_sum;
   logic signed [27:0] integ_sum;
   logic signed [31:0] lim_pos;
   logic signed [31:0] lim_neg;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff       <= '0;
         gain_d_ff       <= '0;
         gain_i_ff       <= '0;
         torque_limit_ff <= ptq_pkg::TORQUE_LIMIT_RESET;
         filter_alpha_ff <= ptq_pkg::FILTER_ALPHA_RESET;
         time_step_ff    <= ptq_pkg::TIME_STEP_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            ptq_pkg::REG_GAIN_P:       gain_p_ff       <= csr_data;
            ptq_pkg::REG_GAIN_D:       gain_d_ff       <= csr_data;
            ptq_pkg::REG_GAIN_I:       gain_i_ff       <= csr_data;
            ptq_pkg::REG_TORQUE_LIMIT: torque_limit_ff <= csr_data[22:0];
            ptq_pkg::REG_FILTER_ALPHA: filter_alpha_ff <= csr_data[16:0];
            ptq_pkg::REG_TIME_STEP:    time_step_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign alpha_eff  = (filter_alpha_ff > ptq_pkg::ALPHA_ONE) ? ptq_pkg::ALPHA_ONE
                                                              : filter_alpha_ff;
   assign alpha_rest = ptq_pkg::ALPHA_ONE - alpha_eff;
   assign verr       = {dvel_ff[19], dvel_ff} - {fv_ff[19], fv_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mvel_ff <= req_data.measured_vel;
         dvel_ff <= req_data.desired_vel;
         perr_ff <= {req_data.desired_pos[19], req_data.desired_pos}
                  - {req_data.measured_pos[19], req_data.measured_pos};
      end
   end

   // shared multiplier, 25 x 22 signed
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_op)
         ptq_pkg::MUL_FV_OLD: begin
            mul_a = signed'({8'b0, alpha_rest});
            mul_b = {{2{fv_ff[19]}}, fv_ff};
         end
         ptq_pkg::MUL_FV_NEW: begin
            mul_a = signed'({8'b0, alpha_eff});
            mul_b = {{2{mvel_ff[19]}}, mvel_ff};
         end
         ptq_pkg::MUL_INTEG: begin
            mul_a = signed'({1'b0, time_step_ff});
            mul_b = {perr_ff[20], perr_ff};
         end
         ptq_pkg::MUL_PROP: begin
            mul_a = signed'({1'b0, gain_p_ff});
            mul_b = {perr_ff[20], perr_ff};
         end
         ptq_pkg::MUL_DERIV: begin
            mul_a = signed'({1'b0, gain_d_ff});
            mul_b = {verr[20], verr};
         end
         ptq_pkg::MUL_GAIN_I: begin
            mul_a = signed'({1'b0, gain_i_ff});
            mul_b = integ_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.acc_op == ptq_pkg::ACC_LOAD) begin
         acc_ff <= prod_ff;
      end
   end

   assign filt_sum  = {acc_ff[46], acc_ff} + {prod_ff[46], prod_ff};
   assign integ_sum = {{6{integ_ff[21]}}, integ_ff} + {prod_ff[46], prod_ff[46:20]};

   always_comb begin
      fv_in    = fv_ff;
      integ_in = integ_ff;
      tau_in   = tau_ff;
      case (cmd.acc_op)
         ptq_pkg::ACC_FILTER: begin
            fv_in = filt_sum[35:16];
         end
         ptq_pkg::ACC_INTEG: begin
            if (integ_sum > ptq_pkg::INTEG_ONE) begin
               integ_in = ptq_pkg::INTEG_ONE[21:0];
            end else if (integ_sum < ptq_pkg::INTEG_NEG_ONE) begin
               integ_in = ptq_pkg::INTEG_NEG_ONE[21:0];
            end else begin
               integ_in = integ_sum[21:0];
            end
         end
         ptq_pkg::ACC_TAU_P: begin
            tau_in = {prod_ff[46], prod_ff[46:16]};
         end
         ptq_pkg::ACC_TAU_D: begin
            tau_in = tau_ff + {prod_ff[46], prod_ff[46:16]};
         end
         ptq_pkg::ACC_TAU_I: begin
            tau_in = tau_ff + {{5{prod_ff[46]}}, prod_ff[46:20]};
         end
         default: begin
            tau_in = tau_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff    <= '0;
         integ_ff <= '0;
      end else begin
         fv_ff    <= fv_in;
         integ_ff <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      tau_ff <= tau_in;
   end

   // symmetric torque clamp
   assign lim_pos = signed'({9'b0, torque_limit_ff});
   assign lim_neg = -lim_pos;

   always_comb begin
      rsp_data_in.torque         = tau_ff[23:0];
      rsp_data_in.torque_clamped = 1'b0;
      if (tau_ff > lim_pos) begin
         rsp_data_in.torque         = lim_pos[23:0];
         rsp_data_in.torque_clamped = 1'b1;
      end else if (tau_ff < lim_neg) begin
         rsp_data_in.torque         = lim_neg[23:0];
         rsp_data_in.torque_clamped = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign sts.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

endmodule

@@ design/pid_torque_with_filter_and_clamps_unit.sv @@
`timescale 1ns / 1ps

// One joint's PID servo step: low-pass filter on measured velocity, integral of
// position error with anti-windup clamp at +-1.0, torque = P + D + I clamped to
// +-torque_limit with a clamp flag. One item is taken at a time; an accepted item
// steps through ST_FV_OLD, ST_FV_NEW, ST_INTEG, ST_PROP, ST_DERIV, ST_GAIN_I and
// ST_SUM_I (six products in sequence through the single shared 25x22 multiplier),
// then ST_OUT clamps and loads the result, waiting only while the result register
// is still held by the consumer. The result register lets the next item in while
// the previous result waits. Gains, limit, filter weight and period are written
// through the csr_ port; write them only while the block is idle.
module pid_torque_with_filter_and_clamps_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [ptq_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ptq_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  ptq_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output ptq_pkg::rsp_type                    rsp_data
);

   ptq_pkg::cmd_type cmd;
   ptq_pkg::sts_type sts;

   ptq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ptq_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_data         (req_data),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data)
   );

endmodule

@@ tb/tb_pid_torque_with_filter_and_clamps_unit.sv @@
`timescale 1ns / 1ps

module tb_pid_torque_with_filter_and_clamps_unit;

   localparam int FIELD_MAX   = 524287;
   localparam int FIELD_MIN   = -524288;
   localparam int GROUP_COUNT = 12;
   localparam int GROUP_ITEMS = 50;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int MAX_PRINTS  = 40;

   // indexes the block does not decode
   localparam logic [ptq_pkg::CSR_INDEX_WIDTH-1:0] REG_SPARE_A = 3'd6;
   localparam logic [ptq_pkg::CSR_INDEX_WIDTH-1:0] REG_SPARE_B = 3'd7;

   typedef struct {
      logic [ptq_pkg::CSR_INDEX_WIDTH-1:0] idx;
      logic [ptq_pkg::CSR_DATA_WIDTH-1:0]  val;
   } csr_write_type;

   class pid_torque_checker;
      logic [23:0]      kp, kd, ki, tstep;
      logic [22:0]      limit;
      logic [16:0]      alpha;
      longint           filt_vel, integ_err;
      ptq_pkg::rsp_type torque_due[$];
      int               errors, items_taken, torques_seen, clamps_seen;

      function new();
         kp = '0;
         kd = '0;
         ki = '0;
         limit = ptq_pkg::TORQUE_LIMIT_RESET;
         alpha = ptq_pkg::FILTER_ALPHA_RESET;
         tstep = ptq_pkg::TIME_STEP_RESET;
         filt_vel = 0;
         integ_err = 0;
         errors = 0;
         items_taken = 0;
         torques_seen = 0;
         clamps_seen = 0;
      endfunction

      function void set_reg(logic [ptq_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            logic [ptq_pkg::CSR_DATA_WIDTH-1:0] val);
         case (idx)
            ptq_pkg::REG_GAIN_P:       kp = val;
            ptq_pkg::REG_GAIN_D:       kd = val;
            ptq_pkg::REG_GAIN_I:       ki = val;
            ptq_pkg::REG_TORQUE_LIMIT: limit = val[22:0];
            ptq_pkg::REG_FILTER_ALPHA: alpha = val[16:0];
            ptq_pkg::REG_TIME_STEP:    tstep = val;
            default: ;
         endcase
      endfunction

      function void servo_step(ptq_pkg::req_type r);
         longint           mpos, mvel, dpos, dvel, a, lim, perr, verr, tau;
         ptq_pkg::rsp_type e;
         mpos = r.measured_pos;
         mvel = r.measured_vel;
         dpos = r.desired_pos;
         dvel = r.desired_vel;
         a = (alpha > ptq_pkg::ALPHA_ONE) ? longint'(ptq_pkg::ALPHA_ONE) : longint'(alpha);
         lim = longint'(limit);
         filt_vel = ((longint'(ptq_pkg::ALPHA_ONE) - a) * filt_vel + a * mvel) >>> 16;
         perr = dpos - mpos;
         verr = dvel - filt_vel;
         integ_err += (perr * longint'(tstep)) >>> 20;
         if (integ_err > longint'(ptq_pkg::INTEG_ONE))
            integ_err = longint'(ptq_pkg::INTEG_ONE);
         if (integ_err < longint'(ptq_pkg::INTEG_NEG_ONE))
            integ_err = longint'(ptq_pkg::INTEG_NEG_ONE);
         tau = ((longint'(kp) * perr) >>> 16) + ((longint'(kd) * verr) >>> 16)
             + ((longint'(ki) * integ_err) >>> 20);
         e.torque_clamped = 1'b0;
         if (tau > lim) begin
            tau = lim;
            e.torque_clamped = 1'b1;
         end else if (tau < -lim) begin
            tau = -lim;
            e.torque_clamped = 1'b1;
         end
         e.torque = tau[23:0];
         torque_due = {torque_due, e};
         items_taken++;
      endfunction

      task report(string msg);
         if (errors < MAX_PRINTS)
            $display("[%0t] torque check: %s", $time, msg);
         errors++;
      endtask

      task check_torque(ptq_pkg::rsp_type got);
         ptq_pkg::rsp_type want;
         torques_seen++;
         if (got.torque_clamped)
            clamps_seen++;
         if (torque_due.size() == 0) begin
            report($sformatf("unexpected item, torque %0d clamped %0b",
                             got.torque, got.torque_clamped));
         end else begin
            want = torque_due.pop_front();
            if (got.torque !== want.torque)
               report($sformatf("torque %0d, want %0d", got.torque, want.torque));
            if (got.torque_clamped !== want.torque_clamped)
               report($sformatf("clamp flag %0b, want %0b",
                                got.torque_clamped, want.torque_clamped));
         end
      endtask

      function int pending();
         return torque_due.size();
      endfunction
   endclass

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                csr_write_enable = 1'b0;
   logic [ptq_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [ptq_pkg::CSR_DATA_WIDTH-1:0]  csr_data = '0;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   ptq_pkg::req_type                    req_data = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   ptq_pkg::rsp_type                    rsp_data;

   pid_torque_checker checker_sb = new();
   csr_write_type     csr_pending[$];
   int                send_idle_pct = 0;
   int                rcv_stall_pct = 0;
   int                stall_cycles = 0;
   int                settings_used = 0;

   pid_torque_with_filter_and_clamps_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            checker_sb.check_torque(rsp_data);
         rsp_ready <= (int'($urandom_range(99)) >= rcv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
         $display("pid_torque_with_filter_and_clamps_unit: mismatch");
         $finish;
      end
   end

   function automatic ptq_pkg::req_type make_req(int mp, int mv, int dp, int dv);
      ptq_pkg::req_type r;
      r.measured_pos = mp[19:0];
      r.measured_vel = mv[19:0];
      r.desired_pos  = dp[19:0];
      r.desired_vel  = dv[19:0];
      return r;
   endfunction

   function automatic int pick_edge_value();
      case ($urandom_range(4))
         0: return FIELD_MAX;
         1: return FIELD_MIN;
         2: return 0;
         3: return -1;
         default: return int'($urandom_range(1048575)) + FIELD_MIN;
      endcase
   endfunction

   function automatic ptq_pkg::req_type random_req();
      logic [95:0] bits;
      int          base, vel;
      bits = {$urandom, $urandom, $urandom};
      case ($urandom_range(9))
         6, 7: return bits[79:0];
         8, 9: return make_req(pick_edge_value(), pick_edge_value(),
                               pick_edge_value(), pick_edge_value());
         default: begin
            // joint tracking its setpoint: small errors, random content
            base = int'($urandom_range(1000000)) - 500000;
            vel  = int'($urandom_range(400000)) - 200000;
            return make_req(base + int'($urandom_range(8192)) - 4096,
                            vel + int'($urandom_range(16384)) - 8192,
                            base, vel);
         end
      endcase
   endfunction

   task send_item(ptq_pkg::req_type item);
      while (int'($urandom_range(99)) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_data  <= {$urandom, $urandom, 16'($urandom)};
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do
         @(posedge clock);
      while (!req_ready);
      checker_sb.servo_step(item);
   endtask

   task drain();
      req_valid <= 1'b0;
      while (checker_sb.pending() != 0)
         @(posedge clock);
   endtask

   task queue_csr(logic [ptq_pkg::CSR_INDEX_WIDTH-1:0] idx,
                  logic [ptq_pkg::CSR_DATA_WIDTH-1:0] val);
      csr_write_type w;
      w.idx = idx;
      w.val = val;
      csr_pending = {csr_pending, w};
   endtask

   task apply_csr();
      csr_write_type w;
      while (csr_pending.size() != 0) begin
         w = csr_pending.pop_front();
         csr_write_enable <= 1'b1;
         csr_index        <= w.idx;
         csr_data         <= w.val;
         @(posedge clock);
         checker_sb.set_reg(w.idx, w.val);
      end
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   task queue_setting(int unsigned g);
      case (g % 6)
         1: begin
            queue_csr(ptq_pkg::REG_GAIN_P, 24'hFFFFFF);
            queue_csr(ptq_pkg::REG_GAIN_D, 24'hFFFFFF);
            queue_csr(ptq_pkg::REG_GAIN_I, 24'hFFFFFF);
            queue_csr(ptq_pkg::REG_TORQUE_LIMIT, 24'h7FFFFF);
            queue_csr(ptq_pkg::REG_FILTER_ALPHA, 24'h01FFFF);
            queue_csr(ptq_pkg::REG_TIME_STEP, 24'hFFFFFF);
         end
         3: begin
            queue_csr(ptq_pkg::REG_GAIN_P, 24'($urandom_range(24'hFFFFFF)));
            queue_csr(ptq_pkg::REG_GAIN_D, 24'($urandom_range(24'hFFFFFF)));
            queue_csr(ptq_pkg::REG_GAIN_I, 24'($urandom_range(24'hFFFFFF)));
            queue_csr(ptq_pkg::REG_TORQUE_LIMIT, 24'd0);
            queue_csr(ptq_pkg::REG_FILTER_ALPHA, 24'd0);
            queue_csr(ptq_pkg::REG_TIME_STEP, 24'd0);
         end
         5: begin
            queue_csr(ptq_pkg::REG_GAIN_P, 24'($urandom_range(24'hFFFFFF)));
            queue_csr(ptq_pkg::REG_GAIN_D, 24'($urandom_range(24'hFFFFFF)));
            queue_csr(ptq_pkg::REG_GAIN_I, 24'($urandom_range(24'hFFFFFF)));
            queue_csr(ptq_pkg::REG_TORQUE_LIMIT, 24'($urandom_range(24'hFFFFFF)));
            queue_csr(ptq_pkg::REG_FILTER_ALPHA, 24'($urandom_range(24'hFFFFFF)));
            queue_csr(ptq_pkg::REG_TIME_STEP, 24'($urandom_range(24'hFFFFFF)));
            queue_csr(REG_SPARE_A, 24'($urandom_range(24'hFFFFFF)));
         end
         default: begin
            // moderate gains so most torques stay inside the limit
            queue_csr(ptq_pkg::REG_GAIN_P, 24'($urandom_range(1 << 14)));
            queue_csr(ptq_pkg::REG_GAIN_D, 24'($urandom_range(1 << 14)));
            queue_csr(ptq_pkg::REG_GAIN_I, 24'($urandom_range(1 << 14)));
            queue_csr(ptq_pkg::REG_TORQUE_LIMIT,
                      24'($urandom_range(24'h7FFFFF, 1 << 16)));
            queue_csr(ptq_pkg::REG_FILTER_ALPHA, 24'($urandom_range(65536)));
            queue_csr(ptq_pkg::REG_TIME_STEP, 24'($urandom_range(1 << 20)));
         end
      endcase
   endtask

   initial begin
      int unsigned g;
      int          n;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 29;
      rcv_stall_pct = 77;

      // directed: integral saturation both ways, field extremes, alpha above one
      queue_csr(ptq_pkg::REG_GAIN_P, 24'd4096);
      queue_csr(ptq_pkg::REG_GAIN_D, 24'd4096);
      queue_csr(ptq_pkg::REG_GAIN_I, 24'd4096);
      queue_csr(ptq_pkg::REG_TORQUE_LIMIT, 24'd65536);
      queue_csr(ptq_pkg::REG_FILTER_ALPHA, 24'd65636);
      queue_csr(ptq_pkg::REG_TIME_STEP, 24'hFFFFFF);
      queue_csr(REG_SPARE_A, 24'd0);
      queue_csr(REG_SPARE_B, 24'hFFFFFF);
      apply_csr();
      send_item(make_req(0, 0, 0, 0));
      send_item(make_req(FIELD_MIN, 0, FIELD_MAX, 0));
      send_item(make_req(FIELD_MIN, 0, FIELD_MAX, 0));
      send_item(make_req(FIELD_MAX, 0, FIELD_MIN, 0));
      send_item(make_req(FIELD_MAX, 0, FIELD_MIN, 0));
      send_item(make_req(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX));
      send_item(make_req(FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN));
      send_item(make_req(0, FIELD_MIN, 0, FIELD_MAX));
      send_item(make_req(0, FIELD_MAX, 0, FIELD_MIN));
      send_item(make_req(100, -1, 90, 1));
      drain();

      queue_csr(ptq_pkg::REG_TORQUE_LIMIT, 24'd0);
      queue_csr(ptq_pkg::REG_FILTER_ALPHA, 24'd0);
      apply_csr();
      send_item(make_req(FIELD_MIN, FIELD_MAX, FIELD_MAX, FIELD_MIN));
      send_item(make_req(0, 0, 0, 0));
      send_item(make_req(FIELD_MAX, FIELD_MIN, FIELD_MIN, FIELD_MAX));
      drain();

      queue_csr(ptq_pkg::REG_GAIN_P, 24'hFFFFFF);
      queue_csr(ptq_pkg::REG_GAIN_D, 24'd0);
      queue_csr(ptq_pkg::REG_GAIN_I, 24'hFFFFFF);
      queue_csr(ptq_pkg::REG_TORQUE_LIMIT, 24'hFFFFFF);
      queue_csr(ptq_pkg::REG_FILTER_ALPHA, 24'd65536);
      queue_csr(ptq_pkg::REG_TIME_STEP, 24'd0);
      apply_csr();
      send_item(make_req(FIELD_MIN, FIELD_MAX, FIELD_MAX, FIELD_MAX));
      send_item(make_req(FIELD_MAX, FIELD_MIN, FIELD_MIN, FIELD_MIN));
      send_item(make_req(-1, 1, 1, -1));
      send_item(make_req(0, 0, 0, 0));
      drain();

      for (g = 0; g < GROUP_COUNT; g++) begin
         if (g < 4) begin
            send_idle_pct = 29;
            rcv_stall_pct = 77;
         end else if (g < 8) begin
            send_idle_pct = 77;
            rcv_stall_pct = 29;
         end else begin
            send_idle_pct = 0;
            rcv_stall_pct = 0;
         end
         queue_setting(g);
         apply_csr();
         for (n = 0; n < GROUP_ITEMS; n++)
            send_item(random_req());
         drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d items under %0d register settings, %0d torques clamped",
               checker_sb.items_taken, settings_used, checker_sb.clamps_seen);
      $display("%0d torques checked, %0d mismatches", checker_sb.torques_seen,
               checker_sb.errors);
      if (checker_sb.errors == 0 && checker_sb.pending() == 0)
         $display("pid_torque_with_filter_and_clamps_unit: match");
      else
         $display("pid_torque_with_filter_and_clamps_unit: mismatch");
      $finish;
   end

endmodule
